@@ rtl/core/cpsm_pkg.sv @@
// Shared types and constants for the capture pair speed meter.
// No dependencies; imported by cpsm_divider, capture_pair_speed_meter and its bench.
package cpsm_pkg;

	localparam int TIMER_BITS       = 32;
	localparam int DIST_BITS        = 10;
	localparam int SPEED_BITS       = 16;
	localparam int CFG_INDEX_BITS   = 2;
	localparam int CFG_DATA_BITS    = 32;
	localparam int STAMP_BITS       = 32;
	localparam int TICKS_PER_SECOND = 1000000;

	// widest dividend: largest distance times ticks per second
	localparam int NUM_BITS = $clog2((2**DIST_BITS - 1) * TICKS_PER_SECOND + 1);
	localparam int CNT_BITS = $clog2(NUM_BITS + 1);

	localparam logic [STAMP_BITS-1:0] TIMER_MASK =
		STAMP_BITS'((64'd1 << TIMER_BITS) - 64'd1);
	localparam logic [SPEED_BITS-1:0] SPEED_MAX = {SPEED_BITS{1'b1}};

	localparam logic [DIST_BITS-1:0]  DIST_RESET   = DIST_BITS'(50);
	localparam logic [STAMP_BITS-1:0] PERIOD_RESET = STAMP_BITS'(1000000);

	// register indexes on the configuration channel
	localparam logic [CFG_INDEX_BITS-1:0] REG_DISTANCE   = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_PERIOD = CFG_INDEX_BITS'(1);

	typedef struct packed {
		logic                  start;
		logic [NUM_BITS-1:0]   num;
		logic [TIMER_BITS-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                busy;
		logic                done;
		logic [NUM_BITS-1:0] quot;
	} div_rsp_t;

endpackage

@@ rtl/core/cpsm_divider.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on cpsm_pkg (widths, div_req_t, div_rsp_t).
module cpsm_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  cpsm_pkg::div_req_t req,
	output cpsm_pkg::div_rsp_t rsp
);
	import cpsm_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_BITS-1:0]   count_q;
	logic [TIMER_BITS-1:0] rem_q;
	logic [TIMER_BITS-1:0] den_q;
	logic [NUM_BITS-1:0]   quo_q;   // dividend bits shift out, quotient bits shift in

	logic [TIMER_BITS:0]   trial;
	logic                  take;

	assign trial = {rem_q, quo_q[NUM_BITS-1]};
	assign take  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q  <= 1'b1;
				count_q <= CNT_BITS'(NUM_BITS);
			end else if (busy_q) begin
				count_q <= count_q - CNT_BITS'(1);
				if (count_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.den;
			quo_q <= req.num;
		end else if (busy_q) begin
			rem_q <= take ? TIMER_BITS'(trial - {1'b0, den_q}) : trial[TIMER_BITS-1:0];
			quo_q <= {quo_q[NUM_BITS-2:0], take};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

@@ rtl/core/capture_pair_speed_meter.sv @@
// Top level of the capture pair speed meter: poll sequencer, state, output register.
// Depends on cpsm_pkg and cpsm_divider.

// Each input beat is one poll of a capture unit. Captures are paired: the
// first stamp of a pair is stored, the second gives the period (modular
// timer difference) and, if nonzero and below max_period, the speed
// floor(distance * 1000000 / period), saturated at 65535 and held.
// Every poll gives exactly one output beat. A poll that completes a valid
// pair passes through the check, the divider handoff, the single restoring
// divider, which retires one quotient bit per cycle over the 30-bit
// dividend, the result load and the idle slot. Any other poll goes from the
// check straight to the result load and the idle slot. One poll is worked
// on at a time; in_ready is high only between polls. The output register
// lets the next poll be taken while a result waits; a result still held
// when the next one is ready stalls the block cycle for cycle. Configuration
// writes are always accepted and are meant to be issued while the block is
// idle; unused indexes are ignored.
module capture_pair_speed_meter (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  capture_seen,
	input  logic [cpsm_pkg::STAMP_BITS-1:0]       capture_time,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [cpsm_pkg::SPEED_BITS-1:0]       speed,
	output logic                                  fresh,
	output logic                                  clipped,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [cpsm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [cpsm_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
	import cpsm_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]            state_q;
	logic [DIST_BITS-1:0]  distance_q;
	logic [STAMP_BITS-1:0] max_period_q;

	logic                  seen_q;
	logic [STAMP_BITS-1:0] stamp_q;
	logic [STAMP_BITS-1:0] first_stamp_q;
	logic                  awaiting_q;
	logic [SPEED_BITS-1:0] held_speed_q;
	logic                  fresh_q;
	logic                  clipped_q;

	logic                  out_valid_q;
	logic [SPEED_BITS-1:0] out_speed_q;
	logic                  out_fresh_q;
	logic                  out_clipped_q;

	logic [STAMP_BITS-1:0] period;
	logic                  period_ok;
	logic                  out_free;
	logic                  quot_big;
	div_req_t              div_req;
	div_rsp_t              div_rsp;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	assign period    = (stamp_q - first_stamp_q) & TIMER_MASK;
	assign period_ok = (period != '0) && (period < max_period_q);
	assign out_free  = !out_valid_q || out_ready;
	assign quot_big  = div_rsp.quot > NUM_BITS'(SPEED_MAX);

	assign div_req.start = (state_q == ST_CHECK) && seen_q && awaiting_q && period_ok;
	assign div_req.num   = NUM_BITS'(distance_q) * NUM_BITS'(TICKS_PER_SECOND);
	assign div_req.den   = period[TIMER_BITS-1:0];

	cpsm_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			distance_q   <= DIST_RESET;
			max_period_q <= PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_DISTANCE) begin
				distance_q <= cfg_data[DIST_BITS-1:0];
			end else if (cfg_index == REG_MAX_PERIOD) begin
				max_period_q <= cfg_data[STAMP_BITS-1:0];
			end
		end
	end

	// sequencer and measurement state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			first_stamp_q <= '0;
			awaiting_q    <= 1'b0;
			held_speed_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (seen_q && !awaiting_q) begin
						first_stamp_q <= stamp_q;
						awaiting_q    <= 1'b1;
						state_q       <= ST_DONE;
					end else if (seen_q) begin
						awaiting_q <= 1'b0;
						state_q    <= period_ok ? ST_WAIT : ST_DONE;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_WAIT: begin
					if (div_rsp.done) begin
						held_speed_q <= quot_big ? SPEED_MAX : div_rsp.quot[SPEED_BITS-1:0];
						state_q      <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output beat valid: loaded from the sequencer, dropped once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// poll capture, result flags and output payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			seen_q  <= capture_seen;
			stamp_q <= capture_time & TIMER_MASK;
		end
		if (state_q == ST_CHECK) begin
			fresh_q   <= 1'b0;
			clipped_q <= 1'b0;
		end else if (state_q == ST_WAIT && div_rsp.done) begin
			fresh_q   <= 1'b1;
			clipped_q <= quot_big;
		end
		if (state_q == ST_DONE && out_free) begin
			out_speed_q   <= held_speed_q;
			out_fresh_q   <= fresh_q;
			out_clipped_q <= clipped_q;
		end
	end

	assign out_valid = out_valid_q;
	assign speed     = out_speed_q;
	assign fresh     = out_fresh_q;
	assign clipped   = out_clipped_q;

	// a saturated result is always a fresh one at full scale
	a_clip_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_clipped_q |-> out_fresh_q && out_speed_q == SPEED_MAX)
		else $error("clipped result not fresh or not at full scale");

	// divider is never busy while a new poll can be taken
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_rsp.busy)
		else $error("divider busy while idle");

	// divider completes only while the sequencer waits for it
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_WAIT)
		else $error("divider done outside wait state");

	// an accepted poll closes the input until its result is out
	a_one_poll: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready && state_q == ST_CHECK)
		else $error("input still open after accepting a poll");

	// a division is started only for the second stamp of a pair
	a_start_pair: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |=> !awaiting_q && state_q == ST_WAIT)
		else $error("division started outside a closing pair");

endmodule

@@ tb/capture_pair_speed_meter_tb.sv @@
// Self-checking bench for capture_pair_speed_meter: random capture polls, stalls and register phases.
// Depends on cpsm_pkg and the RTL of the meter; expected readings come from the speed_calc class.
module capture_pair_speed_meter_tb;
	import cpsm_pkg::*;

	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_2 = CFG_INDEX_BITS'(2);
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_3 = CFG_INDEX_BITS'(3);
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [SPEED_BITS-1:0] speed;
		logic                  fresh;
		logic                  clipped;
	} speed_reading_t;

	// Tracks pairing state and registers, and queues the reading each poll should give.
	class speed_calc;
		logic [DIST_BITS-1:0]  dist_cfg;
		logic [STAMP_BITS-1:0] period_limit;
		logic [STAMP_BITS-1:0] pair_start;
		logic                  pair_open;
		logic [SPEED_BITS-1:0] held_reading;
		speed_reading_t        expected_readings[$];
		int                    mismatches;

		function new();
			dist_cfg     = DIST_RESET;
			period_limit = PERIOD_RESET;
			pair_start   = '0;
			pair_open    = 1'b0;
			held_reading = '0;
			mismatches   = 0;
		endfunction

		function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
			case (idx)
				REG_DISTANCE:   dist_cfg = data[DIST_BITS-1:0];
				REG_MAX_PERIOD: period_limit = data[STAMP_BITS-1:0];
				default: ;
			endcase
		endfunction

		function void note_poll(logic seen, logic [STAMP_BITS-1:0] stamp);
			speed_reading_t        r;
			logic [STAMP_BITS-1:0] period;
			logic [63:0]           quot;
			r.fresh   = 1'b0;
			r.clipped = 1'b0;
			if (seen) begin
				if (!pair_open) begin
					pair_start = stamp & TIMER_MASK;
					pair_open  = 1'b1;
				end else begin
					period    = (stamp - pair_start) & TIMER_MASK;
					pair_open = 1'b0;
					if (period != 0 && period < period_limit) begin
						quot = (64'(dist_cfg) * 64'(TICKS_PER_SECOND)) / 64'(period);
						if (quot > 64'(SPEED_MAX)) begin
							quot      = 64'(SPEED_MAX);
							r.clipped = 1'b1;
						end
						held_reading = quot[SPEED_BITS-1:0];
						r.fresh      = 1'b1;
					end
				end
			end
			r.speed = held_reading;
			expected_readings.push_back(r);
		endfunction

		task flag_mismatch(string what);
			mismatches++;
			$display("%0t mismatch: %s", $realtime, what);
		endtask

		task check_reading(logic [SPEED_BITS-1:0] speed, logic fr, logic cl);
			speed_reading_t want;
			if (expected_readings.size() == 0) begin
				flag_mismatch($sformatf("reading with none pending, speed %0d", speed));
				return;
			end
			want = expected_readings.pop_front();
			if (speed !== want.speed)
				flag_mismatch($sformatf("speed %0d, wanted %0d", speed, want.speed));
			if (fr !== want.fresh)
				flag_mismatch($sformatf("fresh %b, wanted %b", fr, want.fresh));
			if (cl !== want.clipped)
				flag_mismatch($sformatf("clipped %b, wanted %b", cl, want.clipped));
		endtask
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic                      capture_seen;
	logic [STAMP_BITS-1:0]     capture_time;
	logic                      out_valid;
	logic                      out_ready;
	logic [SPEED_BITS-1:0]     speed;
	logic                      fresh;
	logic                      clipped;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	speed_calc calc = new();
	bit        quiet = 1'b0;
	bit        hold_req = 1'b0;
	int        idle_cycles = 0;

	capture_pair_speed_meter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.capture_seen (capture_seen),
		.capture_time (capture_time),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.speed        (speed),
		.fresh        (fresh),
		.clipped      (clipped),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// output side: random stall bursts, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				out_ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			calc.check_reading(speed, fresh, clipped);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("capture_pair_speed_meter_tb NOT OK");
				$finish;
			end
		end
	end

	// valid stays high between back-to-back beats; it drops only for a gap
	task automatic send_poll(input logic seen, input logic [STAMP_BITS-1:0] stamp);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		capture_seen <= seen;
		capture_time <= stamp;
		do @(posedge clk); while (!in_ready);
		calc.note_poll(seen, stamp);
	endtask

	task automatic send_pair(input logic [STAMP_BITS-1:0] start, input logic [STAMP_BITS-1:0] period);
		send_poll(1'b1, start);
		send_poll(1'b1, start + period);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (calc.expected_readings.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_regs(input logic [CFG_DATA_BITS-1:0] dist_word,
			input logic [CFG_DATA_BITS-1:0] period_word, input bit with_spare);
		logic [CFG_INDEX_BITS-1:0] idx[$];
		logic [CFG_DATA_BITS-1:0]  val[$];
		idx.push_back(REG_DISTANCE);
		val.push_back(dist_word);
		if (with_spare) begin
			idx.push_back(REG_SPARE_2);
			val.push_back($urandom);
			idx.push_back(REG_SPARE_3);
			val.push_back($urandom);
		end
		idx.push_back(REG_MAX_PERIOD);
		val.push_back(period_word);
		foreach (idx[i]) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			do @(posedge clk); while (!cfg_ready);
			calc.set_reg(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// mostly well-formed pairs; the period lands near the clip knee and the limit often
	function automatic logic [STAMP_BITS-1:0] pick_period();
		logic [63:0]           knee;
		logic [STAMP_BITS-1:0] top;
		knee = (64'(calc.dist_cfg) * 64'(TICKS_PER_SECOND)) / 64'(SPEED_MAX);
		top  = (calc.period_limit > 1) ? calc.period_limit - 1 : 32'd1;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return $urandom_range(1, 64);
			2, 3: return knee[STAMP_BITS-1:0] + $urandom_range(0, 4) - 2;
			4: return calc.period_limit + $urandom_range(0, 2) - 1;
			5: return $urandom;
			6, 7: return $urandom_range(1, (top < 100000) ? top : 100000);
			default: return $urandom_range(1, top);
		endcase
	endfunction

	task automatic random_polls(input int count);
		repeat (count) begin
			if (calc.pair_open) begin
				if ($urandom_range(0, 6) == 0)
					send_poll(1'b0, $urandom);
				else
					send_poll(1'b1, calc.pair_start + pick_period());
			end else begin
				if ($urandom_range(0, 4) == 0)
					send_poll(1'b0, $urandom);
				else
					send_poll(1'b1, $urandom);
			end
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		capture_seen = 1'b0;
		capture_time = '0;
		cfg_valid    = 1'b0;
		cfg_index    = REG_DISTANCE;
		cfg_data     = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: no capture, wrap, zero period, limit edges, clip knee
		send_poll(1'b0, 32'h0000_0000);
		send_poll(1'b0, 32'hFFFF_FFFF);
		send_pair(32'h0000_0000, 32'hFFFF_FFFF);
		send_pair(32'hFFFF_FFF0, 32'h0000_0020);
		send_pair(32'h1234_5678, 32'h0000_0000);
		send_pair(32'hAAAA_AAAA, PERIOD_RESET - 1);
		send_pair(32'h5555_5555, PERIOD_RESET);
		send_pair(32'd100, 32'd1);
		send_poll(1'b1, 32'd7);
		send_poll(1'b0, 32'hDEAD_BEEF);
		send_poll(1'b1, 32'd7 + 32'd763);
		send_pair(32'h8000_0000, 32'd762);
		random_polls(200);
		wait_drained();

		program_regs(32'd1000, 32'hFFFF_FFFF, 1'b0);
		hold_req = 1'b1;
		random_polls(250);
		wait_drained();

		// distance zero, written with the upper bits set so they must be dropped
		program_regs(32'hFFFF_FC00, $urandom, 1'b1);
		random_polls(100);
		wait_drained();

		program_regs(32'd50, 32'd0, 1'b0);
		random_polls(80);
		wait_drained();

		program_regs(32'd1, 32'd1, 1'b1);
		random_polls(60);
		wait_drained();

		program_regs({22'($urandom_range(0, 4194303)), 10'($urandom_range(1, 1000))},
			$urandom_range(1000, 32'hFFFF_FFFF), 1'b0);
		random_polls(200);
		wait_drained();

		quiet = 1'b1;
		program_regs(32'h0000_03FF, 32'd3000000, 1'b0);
		random_polls(350);
		wait_drained();
		repeat (10) @(posedge clk);

		if (calc.mismatches == 0 && calc.expected_readings.size() == 0)
			$display("capture_pair_speed_meter_tb OK");
		else
			$display("capture_pair_speed_meter_tb NOT OK");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/cpsm_pkg.sv
rtl/core/cpsm_divider.sv
rtl/core/capture_pair_speed_meter.sv
tb/capture_pair_speed_meter_tb.sv
